[src/assert_macros.svh]
// Assertion macros shared by the handler stack modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds at a clock edge, cons holds at the same edge.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// When ante holds at a clock edge, cons holds at the next edge.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[src/ehs_pkg.sv]
// Types and constants of the exception handler stack.
`timescale 1ns / 1ps

package ehs_pkg;

   localparam int MAX_HANDLERS_DEF = 64;
   localparam int KIND_W           = 2;
   localparam int WORD_W           = 32;
   localparam int INDEX_W          = 6;
   localparam int DEPTH_W          = 7;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_FIND = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      HT_CATCH         = 2'd0,
      HT_FINALLY       = 2'd1,
      HT_CATCH_FINALLY = 2'd2
   } handler_kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // One request word as it enters the block.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KIND_W-1:0] handler_type;
      logic [WORD_W-1:0] catch_target;
      logic [WORD_W-1:0] finally_target;
      logic [WORD_W-1:0] entry_stack_depth;
      logic [WORD_W-1:0] entry_scope_depth;
   } req_word_type;

   // One stored handler.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] catch_target;
      logic [WORD_W-1:0] finally_target;
      logic [WORD_W-1:0] stack_depth;
      logic [WORD_W-1:0] scope_depth;
   } entry_type;

   // One response word.
   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [INDEX_W-1:0] found_index;
      logic [KIND_W-1:0]  found_type;
      logic [WORD_W-1:0]  found_catch_target;
      logic [WORD_W-1:0]  found_finally_target;
      logic [WORD_W-1:0]  found_stack_depth;
      logic [WORD_W-1:0]  found_scope_depth;
      logic [DEPTH_W-1:0] depth_now;
   } rsp_word_type;

endpackage

[src/ehs_req_if.sv]
// Request channel of the exception handler stack.
`timescale 1ns / 1ps

interface ehs_req_if;
   logic                        valid;
   logic                        ready;
   logic [ehs_pkg::KIND_W-1:0]  kind;
   logic [ehs_pkg::KIND_W-1:0]  handler_type;
   logic [ehs_pkg::WORD_W-1:0]  catch_target;
   logic [ehs_pkg::WORD_W-1:0]  finally_target;
   logic [ehs_pkg::WORD_W-1:0]  entry_stack_depth;
   logic [ehs_pkg::WORD_W-1:0]  entry_scope_depth;

   modport source (
      output valid, kind, handler_type, catch_target, finally_target,
             entry_stack_depth, entry_scope_depth,
      input  ready
   );

   modport sink (
      input  valid, kind, handler_type, catch_target, finally_target,
             entry_stack_depth, entry_scope_depth,
      output ready
   );
endinterface

[src/ehs_rsp_if.sv]
// Response channel of the exception handler stack.
`timescale 1ns / 1ps

interface ehs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic                         found;
   logic [ehs_pkg::INDEX_W-1:0]  found_index;
   logic [ehs_pkg::KIND_W-1:0]   found_type;
   logic [ehs_pkg::WORD_W-1:0]   found_catch_target;
   logic [ehs_pkg::WORD_W-1:0]   found_finally_target;
   logic [ehs_pkg::WORD_W-1:0]   found_stack_depth;
   logic [ehs_pkg::WORD_W-1:0]   found_scope_depth;
   logic [ehs_pkg::DEPTH_W-1:0]  depth_now;

   modport source (
      output valid, status, found, found_index, found_type, found_catch_target,
             found_finally_target, found_stack_depth, found_scope_depth, depth_now,
      input  ready
   );

   modport sink (
      input  valid, status, found, found_index, found_type, found_catch_target,
             found_finally_target, found_stack_depth, found_scope_depth, depth_now,
      output ready
   );
endinterface

[src/ehs_store.sv]
// Single-port-write, registered-read memory holding the handler entries.
`timescale 1ns / 1ps

module ehs_store #(
   parameter int DEPTH = ehs_pkg::MAX_HANDLERS_DEF,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/ehs_ctrl.sv]
// Sequencer of the handler stack: depth counter, running search summary, memory access.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ehs_ctrl #(
   parameter int MAX_HANDLERS = ehs_pkg::MAX_HANDLERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  ehs_pkg::req_word_type req_word,
   output logic                  req_ready,
   input  logic                  out_free,
   output logic                  res_valid,
   output ehs_pkg::rsp_word_type res_word
);

   localparam int IDX_W   = $clog2(MAX_HANDLERS);
   localparam int CNT_W   = $clog2(MAX_HANDLERS + 1);
   localparam int INDEX_W = ehs_pkg::INDEX_W;
   localparam int DEPTH_W = ehs_pkg::DEPTH_W;

   // Innermost catching entry and innermost finally-only entry among
   // all entries from the bottom up to and including a given level.
   typedef struct packed {
      logic             cv;
      logic [IDX_W-1:0] ci;
      logic             fv;
      logic [IDX_W-1:0] fi;
   } summary_type;

   typedef struct packed {
      summary_type        sum;
      ehs_pkg::entry_type ent;
   } mem_word_type;

   localparam int MW = $bits(mem_word_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_RD,
      S_FIND_RD
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   summary_type      sum_ff, sum_in;
   logic [IDX_W-1:0] find_idx_ff, find_idx_in;

   ehs_pkg::op_type  req_op;
   logic             accept;
   logic             full;
   logic             empty;
   logic [IDX_W-1:0] top_idx;
   logic             can_catch;
   logic             fin_only;
   summary_type      push_sum;
   logic             wr_en;
   logic [IDX_W-1:0] rd_addr;
   logic [MW-1:0]    rd_data;
   mem_word_type     rd_word;
   mem_word_type     wr_word;

   assign req_op    = ehs_pkg::op_type'(req_word.kind);
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (cnt_ff == CNT_W'(MAX_HANDLERS));
   assign empty     = (cnt_ff == '0);
   assign top_idx   = cnt_ff[IDX_W-1:0];
   assign can_catch = (req_word.handler_type == ehs_pkg::HT_CATCH) ||
                      (req_word.handler_type == ehs_pkg::HT_CATCH_FINALLY);
   assign fin_only  = (req_word.handler_type == ehs_pkg::HT_FINALLY);

   always_comb begin
      push_sum = sum_ff;
      if (can_catch) begin
         push_sum.cv = 1'b1;
         push_sum.ci = top_idx;
      end
      if (fin_only) begin
         push_sum.fv = 1'b1;
         push_sum.fi = top_idx;
      end
   end

   assign wr_word.sum              = push_sum;
   assign wr_word.ent.kind         = req_word.handler_type;
   assign wr_word.ent.catch_target = req_word.catch_target;
   assign wr_word.ent.finally_target = req_word.finally_target;
   assign wr_word.ent.stack_depth  = req_word.entry_stack_depth;
   assign wr_word.ent.scope_depth  = req_word.entry_scope_depth;
   assign wr_en = accept && (req_op == ehs_pkg::OP_PUSH) && !full;

   // A pop reads the summary stored with the new top entry; a find reads
   // the chosen entry.
   always_comb begin
      if (req_op == ehs_pkg::OP_POP) begin
         rd_addr = IDX_W'(cnt_ff - CNT_W'(2));
      end else if (sum_ff.cv) begin
         rd_addr = sum_ff.ci;
      end else begin
         rd_addr = sum_ff.fi;
      end
   end

   ehs_store #(
      .DEPTH (MAX_HANDLERS),
      .WIDTH (MW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (top_idx),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_word = rd_data;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      find_idx_in = find_idx_ff;
      res_valid   = 1'b0;
      res_word    = '0;
      res_word.depth_now = DEPTH_W'(cnt_ff);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  ehs_pkg::OP_PUSH: begin
                     res_valid = 1'b1;
                     if (full) begin
                        res_word.status = ehs_pkg::STAT_FULL;
                     end else begin
                        cnt_in = cnt_ff + CNT_W'(1);
                        sum_in = push_sum;
                        res_word.depth_now = DEPTH_W'(cnt_ff + CNT_W'(1));
                     end
                  end
                  ehs_pkg::OP_POP: begin
                     if (empty) begin
                        res_valid = 1'b1;
                        res_word.status = ehs_pkg::STAT_EMPTY;
                     end else if (cnt_ff == CNT_W'(1)) begin
                        res_valid = 1'b1;
                        cnt_in = '0;
                        sum_in = '0;
                        res_word.depth_now = '0;
                     end else begin
                        cnt_in   = cnt_ff - CNT_W'(1);
                        state_in = S_POP_RD;
                     end
                  end
                  ehs_pkg::OP_FIND: begin
                     if (sum_ff.cv || sum_ff.fv) begin
                        find_idx_in = sum_ff.cv ? sum_ff.ci : sum_ff.fi;
                        state_in    = S_FIND_RD;
                     end else begin
                        res_valid = 1'b1;
                     end
                  end
                  default: begin
                     res_valid = 1'b1;
                  end
               endcase
            end
         end
         S_POP_RD: begin
            res_valid = 1'b1;
            sum_in    = rd_word.sum;
            state_in  = S_IDLE;
         end
         S_FIND_RD: begin
            res_valid = 1'b1;
            res_word.found                = 1'b1;
            res_word.found_index          = INDEX_W'(find_idx_ff);
            res_word.found_type           = rd_word.ent.kind;
            res_word.found_catch_target   = rd_word.ent.catch_target;
            res_word.found_finally_target = rd_word.ent.finally_target;
            res_word.found_stack_depth    = rd_word.ent.stack_depth;
            res_word.found_scope_depth    = rd_word.ent.scope_depth;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         sum_ff      <= '0;
         find_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         sum_ff      <= sum_in;
         find_idx_ff <= find_idx_in;
      end
   end

   `ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_HANDLERS))
   `ASSERT_IMP(a_busy_holds_req, clock, reset, state_ff != S_IDLE, !req_ready)
   `ASSERT_NXT(a_push_grows, clock, reset, wr_en, cnt_ff == $past(cnt_ff) + CNT_W'(1))
   `ASSERT_IMP(a_find_has_entry, clock, reset, state_ff == S_FIND_RD, sum_ff.cv || sum_ff.fv)

endmodule

[src/exception_handler_stack.sv]
// Top level of the exception handler stack: sequencer and response register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  Channel   Direction  Word carried
//  req_bus   in         operation and, for a push, one handler entry
//  rsp_bus   out        status, found handler fields and depth after the operation
//
//  A push, an ignored pop, a pop down to zero, an unused operation and a find
//  with no handler write their word into the response register on acceptance; a pop
//  that leaves entries and a find that hits first wait in a read state for the
//  registered read of the entry memory. One word is in flight at a time.
//  Reset clears the depth and the search summary; memory contents are not
//  cleared, and only entries below the depth are ever read.
//  A response word waits in its own register, so an idle sequencer takes a new word
//  as long as that register is empty or is being read out in the same cycle.

module exception_handler_stack #(
   parameter int MAX_HANDLERS = ehs_pkg::MAX_HANDLERS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ehs_req_if.sink   req_bus,
   ehs_rsp_if.source rsp_bus
);

   ehs_pkg::req_word_type req_word;
   ehs_pkg::rsp_word_type res_word;
   logic                  res_valid;
   logic                  out_free;
   logic                  req_ready;

   logic                  rsp_valid_ff, rsp_valid_in;
   ehs_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // Gather the request fields into one word for the sequencer.
   assign req_word.kind              = req_bus.kind;
   assign req_word.handler_type      = req_bus.handler_type;
   assign req_word.catch_target      = req_bus.catch_target;
   assign req_word.finally_target    = req_bus.finally_target;
   assign req_word.entry_stack_depth = req_bus.entry_stack_depth;
   assign req_word.entry_scope_depth = req_bus.entry_scope_depth;
   assign req_bus.ready = req_ready;

   // The response register is free when empty or drained at this edge.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   ehs_ctrl #(
      .MAX_HANDLERS (MAX_HANDLERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_word  (req_word),
      .req_ready (req_ready),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The payload needs no reset; it is only looked at while valid is high.
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid                = rsp_valid_ff;
   assign rsp_bus.status               = rsp_word_ff.status;
   assign rsp_bus.found                = rsp_word_ff.found;
   assign rsp_bus.found_index          = rsp_word_ff.found_index;
   assign rsp_bus.found_type           = rsp_word_ff.found_type;
   assign rsp_bus.found_catch_target   = rsp_word_ff.found_catch_target;
   assign rsp_bus.found_finally_target = rsp_word_ff.found_finally_target;
   assign rsp_bus.found_stack_depth    = rsp_word_ff.found_stack_depth;
   assign rsp_bus.found_scope_depth    = rsp_word_ff.found_scope_depth;
   assign rsp_bus.depth_now            = rsp_word_ff.depth_now;

   // A new response word never overwrites one that has not been taken.
   `ASSERT_IMP(a_no_overwrite, clock, reset, res_valid, !rsp_valid_ff || rsp_bus.ready)
   // Nothing is accepted while the register holds a word that stays.
   `ASSERT_IMP(a_no_take_when_blocked, clock, reset, rsp_valid_ff && !rsp_bus.ready, !req_ready)

endmodule

[sim/exception_handler_stack_tb.sv]
// Self-checking testbench for the exception handler stack.
`timescale 1ns / 1ps

// The bench keeps its own copy of the handler stack and predicts one response
// word for every request word that the block accepts. Response words are
// compared field by field, oldest first. Stimulus starts with a short directed
// run through the corner cases. Random segments follow, and each segment has
// its own mix of operations and handler types. That mix walks the depth
// anywhere from empty to overflow.
module exception_handler_stack_tb;

   localparam int WORD_W  = ehs_pkg::WORD_W;
   localparam int INDEX_W = ehs_pkg::INDEX_W;
   localparam int DEPTH_W = ehs_pkg::DEPTH_W;

   // Codes that the package leaves without a name.
   localparam logic [1:0] OP_UNUSED = 2'd3;   // no operation, answered with status ok
   localparam logic [1:0] HT_INERT  = 2'd3;   // stored, but never chosen by a find

   localparam int RANDOM_WORDS = 1200;
   localparam int IDLE_LIMIT   = 3000;        // cycles without any transfer
   localparam int HOLD_CYCLES  = 400;         // long receiver hold-off
   localparam int DRAIN_CYCLES = 10;

   logic clock;
   logic reset;

   ehs_req_if req_bus ();
   ehs_rsp_if rsp_bus ();

   exception_handler_stack dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // The bench's own view of the handler stack.
   ehs_pkg::entry_type handler_entries [ehs_pkg::MAX_HANDLERS_DEF];
   int                 handler_count;

   ehs_pkg::req_word_type request_words [$];   // words still to be offered to the block
   ehs_pkg::rsp_word_type due_responses [$];   // predicted words, oldest first

   int error_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Appends one word to the list of words still to be offered.
   task automatic queue_request(input ehs_pkg::req_word_type w);
      request_words.insert(request_words.size(), w);
   endtask

   // Applies one accepted request word to the stack copy and returns the
   // response word the block must produce for it.
   function automatic ehs_pkg::rsp_word_type apply_stack_op(input ehs_pkg::req_word_type w);
      ehs_pkg::rsp_word_type r;
      int                    hit;
      r      = '0;
      r.status = ehs_pkg::STAT_OK;
      hit    = -1;
      case (w.kind)
         ehs_pkg::OP_PUSH: begin
            if (handler_count >= ehs_pkg::MAX_HANDLERS_DEF) begin
               r.status = ehs_pkg::STAT_FULL;
            end else begin
               handler_entries[handler_count].kind           = w.handler_type;
               handler_entries[handler_count].catch_target   = w.catch_target;
               handler_entries[handler_count].finally_target = w.finally_target;
               handler_entries[handler_count].stack_depth    = w.entry_stack_depth;
               handler_entries[handler_count].scope_depth    = w.entry_scope_depth;
               handler_count++;
            end
         end
         ehs_pkg::OP_POP: begin
            if (handler_count == 0) begin
               r.status = ehs_pkg::STAT_EMPTY;
            end else begin
               handler_count--;
            end
         end
         ehs_pkg::OP_FIND: begin
            // The innermost entry that can catch wins. A catch-finally entry
            // counts as one that can catch, so the fallback search only takes
            // plain try-finally entries.
            for (int i = handler_count - 1; i >= 0 && hit < 0; i--) begin
               if (handler_entries[i].kind == ehs_pkg::HT_CATCH ||
                   handler_entries[i].kind == ehs_pkg::HT_CATCH_FINALLY) begin
                  hit = i;
               end
            end
            for (int i = handler_count - 1; i >= 0 && hit < 0; i--) begin
               if (handler_entries[i].kind == ehs_pkg::HT_FINALLY) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               r.found                = 1'b1;
               r.found_index          = INDEX_W'(hit);
               r.found_type           = handler_entries[hit].kind;
               r.found_catch_target   = handler_entries[hit].catch_target;
               r.found_finally_target = handler_entries[hit].finally_target;
               r.found_stack_depth    = handler_entries[hit].stack_depth;
               r.found_scope_depth    = handler_entries[hit].scope_depth;
            end
         end
         default: begin
         end
      endcase
      r.depth_now = DEPTH_W'(handler_count);
      return r;
   endfunction

   // Payload values favor the two extremes now and then.
   function automatic logic [WORD_W-1:0] pick_payload(input int pattern);
      int roll;
      roll = $urandom_range(0, 7);
      if (pattern == 1) return '0;
      if (pattern == 2) return '1;
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom;
   endfunction

   // Pattern 0 gives random payload, 1 all zeros and 2 all ones.
   function automatic ehs_pkg::req_word_type make_request(input logic [1:0] op,
                                                          input logic [1:0] htype,
                                                          input int pattern);
      ehs_pkg::req_word_type w;
      w.kind              = op;
      w.handler_type      = htype;
      w.catch_target      = pick_payload(pattern);
      w.finally_target    = pick_payload(pattern);
      w.entry_stack_depth = pick_payload(pattern);
      w.entry_scope_depth = pick_payload(pattern);
      return w;
   endfunction

   // Each side draws a random wait after each word unless it is in an eager stretch.
   function automatic int draw_wait(input bit eager);
      return eager ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // Driver. A word stays on the bus until the block takes it. The word is
   // predicted at the edge where it is taken. The next word then follows
   // after a drawn number of idle cycles.
   ehs_pkg::req_word_type word_on_bus;
   int                    send_wait;
   bit                    sender_eager;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_wait    = 0;
         sender_eager = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            due_responses.insert(due_responses.size(), apply_stack_op(word_on_bus));
            if ($urandom_range(0, 39) == 0) sender_eager = ~sender_eager;
            send_wait = draw_wait(sender_eager);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_wait == 0 && request_words.size() != 0) begin
               word_on_bus = request_words.pop_front();
               req_bus.kind              <= word_on_bus.kind;
               req_bus.handler_type      <= word_on_bus.handler_type;
               req_bus.catch_target      <= word_on_bus.catch_target;
               req_bus.finally_target    <= word_on_bus.finally_target;
               req_bus.entry_stack_depth <= word_on_bus.entry_stack_depth;
               req_bus.entry_scope_depth <= word_on_bus.entry_scope_depth;
               req_bus.valid             <= 1'b1;
            end else begin
               if (send_wait > 0) send_wait--;
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each response word is checked against the oldest prediction.
   // After the 150th and the 700th word the receiver holds off for a long
   // stretch. During that stretch the block fills up and has to stall its
   // request side.
   ehs_pkg::rsp_word_type seen_word;
   ehs_pkg::rsp_word_type want_word;
   int                    recv_wait;
   int                    hold_left;
   int                    words_checked;
   bit                    receiver_eager;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_wait      = 0;
         hold_left      = 0;
         words_checked  = 0;
         receiver_eager = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_word.status               = rsp_bus.status;
            seen_word.found                = rsp_bus.found;
            seen_word.found_index          = rsp_bus.found_index;
            seen_word.found_type           = rsp_bus.found_type;
            seen_word.found_catch_target   = rsp_bus.found_catch_target;
            seen_word.found_finally_target = rsp_bus.found_finally_target;
            seen_word.found_stack_depth    = rsp_bus.found_stack_depth;
            seen_word.found_scope_depth    = rsp_bus.found_scope_depth;
            seen_word.depth_now            = rsp_bus.depth_now;
            if (due_responses.size() == 0) begin
               error_count++;
               $display("%0t ns: response word expected none, got %0h",
                        $time, seen_word);
            end else begin
               want_word = due_responses.pop_front();
               compare_field("status", WORD_W'(want_word.status),
                             WORD_W'(seen_word.status));
               compare_field("found", WORD_W'(want_word.found),
                             WORD_W'(seen_word.found));
               compare_field("found_index", WORD_W'(want_word.found_index),
                             WORD_W'(seen_word.found_index));
               compare_field("found_type", WORD_W'(want_word.found_type),
                             WORD_W'(seen_word.found_type));
               compare_field("found_catch_target", want_word.found_catch_target,
                             seen_word.found_catch_target);
               compare_field("found_finally_target", want_word.found_finally_target,
                             seen_word.found_finally_target);
               compare_field("found_stack_depth", want_word.found_stack_depth,
                             seen_word.found_stack_depth);
               compare_field("found_scope_depth", want_word.found_scope_depth,
                             seen_word.found_scope_depth);
               compare_field("depth_now", WORD_W'(want_word.depth_now),
                             WORD_W'(seen_word.depth_now));
            end
            words_checked++;
            if (words_checked == 150 || words_checked == 700) hold_left = HOLD_CYCLES;
            if ($urandom_range(0, 39) == 0) receiver_eager = ~receiver_eager;
            recv_wait = draw_wait(receiver_eager);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: the run is stuck if no word moves on either side for too long.
   int idle_cycles;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("exception_handler_stack_tb failed");
            $finish;
         end
      end
   end

   // Stimulus and end of run.
   int         random_count;
   int         seg_len;
   int         push_pct;
   int         type_mix;
   int         roll;
   logic [1:0] op;
   logic [1:0] htype;

   initial begin
      reset         = 1'b1;
      error_count   = 0;
      handler_count = 0;
      req_bus.valid             = 1'b0;
      req_bus.kind              = '0;
      req_bus.handler_type      = '0;
      req_bus.catch_target      = '0;
      req_bus.finally_target    = '0;
      req_bus.entry_stack_depth = '0;
      req_bus.entry_scope_depth = '0;
      rsp_bus.ready             = 1'b0;

      // Directed part. It starts on the empty stack with a pop and a find.
      queue_request(make_request(ehs_pkg::OP_POP, ehs_pkg::HT_CATCH, 0));
      queue_request(make_request(ehs_pkg::OP_FIND, ehs_pkg::HT_CATCH, 0));
      queue_request(make_request(OP_UNUSED, HT_INERT, 2));
      // An inert handler alone leaves the exception uncaught.
      queue_request(make_request(ehs_pkg::OP_PUSH, HT_INERT, 2));
      queue_request(make_request(ehs_pkg::OP_FIND, ehs_pkg::HT_CATCH, 0));
      // A finally-only handler is taken when nothing can catch.
      queue_request(make_request(ehs_pkg::OP_PUSH, ehs_pkg::HT_FINALLY, 1));
      queue_request(make_request(ehs_pkg::OP_PUSH, HT_INERT, 0));
      queue_request(make_request(ehs_pkg::OP_FIND, ehs_pkg::HT_FINALLY, 0));
      // A catch-finally below a newer finally-only entry still wins.
      queue_request(make_request(ehs_pkg::OP_PUSH, ehs_pkg::HT_CATCH_FINALLY, 2));
      queue_request(make_request(ehs_pkg::OP_PUSH, ehs_pkg::HT_FINALLY, 0));
      queue_request(make_request(ehs_pkg::OP_FIND, HT_INERT, 0));
      queue_request(make_request(ehs_pkg::OP_PUSH, ehs_pkg::HT_CATCH, 0));
      queue_request(make_request(ehs_pkg::OP_FIND, ehs_pkg::HT_CATCH, 1));
      queue_request(make_request(OP_UNUSED, ehs_pkg::HT_CATCH, 1));
      queue_request(make_request(ehs_pkg::OP_POP, ehs_pkg::HT_CATCH, 0));
      queue_request(make_request(ehs_pkg::OP_FIND, ehs_pkg::HT_CATCH, 0));
      queue_request(make_request(ehs_pkg::OP_POP, ehs_pkg::HT_CATCH, 0));
      queue_request(make_request(ehs_pkg::OP_POP, ehs_pkg::HT_CATCH, 0));
      queue_request(make_request(ehs_pkg::OP_FIND, ehs_pkg::HT_CATCH, 0));
      for (int i = 0; i < 4; i++)
         queue_request(make_request(ehs_pkg::OP_POP, ehs_pkg::HT_CATCH, 0));
      queue_request(make_request(ehs_pkg::OP_FIND, ehs_pkg::HT_CATCH, 0));

      // The first random segment fills the stack past its top. Later
      // segments each draw their own push bias and handler type mix.
      for (int i = 0; i < 70; i++)
         queue_request(make_request(ehs_pkg::OP_PUSH, 2'($urandom_range(0, 3)), 0));
      for (int i = 0; i < 3; i++)
         queue_request(make_request(ehs_pkg::OP_FIND, ehs_pkg::HT_CATCH, 0));
      random_count = 73;
      while (random_count < RANDOM_WORDS) begin
         seg_len = $urandom_range(30, 120);
         case ($urandom_range(0, 4))
            0:       push_pct = 15;
            1:       push_pct = 45;
            2:       push_pct = 55;
            3:       push_pct = 85;
            default: push_pct = 97;
         endcase
         type_mix = $urandom_range(0, 2);
         for (int k = 0; k < seg_len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               op = OP_UNUSED;
            end else if (roll < 25) begin
               op = ehs_pkg::OP_FIND;
            end else if ($urandom_range(0, 99) < push_pct) begin
               op = ehs_pkg::OP_PUSH;
            end else begin
               op = ehs_pkg::OP_POP;
            end
            // Finally-only and inert mixes push the search into its fallback
            // and into the uncaught case.
            case (type_mix)
               0: htype = 2'($urandom_range(0, 3));
               1: htype = $urandom_range(0, 1) ? ehs_pkg::HT_FINALLY : HT_INERT;
               default: htype = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                                             : HT_INERT;
            endcase
            queue_request(make_request(op, htype, 0));
         end
         random_count += seg_len;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge, where every process of the rising edge
      // has settled.
      do begin
         @(negedge clock);
      end while (request_words.size() != 0 || req_bus.valid || due_responses.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("exception_handler_stack_tb passed");
      end else begin
         $display("exception_handler_stack_tb failed");
      end
      $finish;
   end

endmodule
